// ===== rtl/ate_pkg.sv =====
// Shared types and constants for the ASCII timestamp to epoch microsecond core.
// No dependencies; imported by every module of the core.
package ate_pkg;

  // One character request on the input side.
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } ate_in_t;

  // One conversion result on the output side.
  typedef struct packed {
    logic signed [59:0] epoch_us;
    logic               format_error;
  } ate_out_t;

  // Parsed token handed from the character front end to the converter.
  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [9:0]  milli;
    logic        format_error;
  } ate_token_t;

  // Trimmed token length; position saturates here.
  localparam logic [4:0] TOKEN_LEN = 5'd21;

  // Last trimmed position of each digit field.
  localparam logic [4:0] POS_YEAR_END   = 5'd3;
  localparam logic [4:0] POS_MONTH_END  = 5'd5;
  localparam logic [4:0] POS_DAY_END    = 5'd7;
  localparam logic [4:0] POS_HOUR_END   = 5'd10;
  localparam logic [4:0] POS_MINUTE_END = 5'd13;
  localparam logic [4:0] POS_SECOND_END = 5'd16;

  // Whitespace and digit codes.
  localparam logic [7:0] CHR_TAB   = 8'd9;
  localparam logic [7:0] CHR_CR    = 8'd13;
  localparam logic [7:0] CHR_SPACE = 8'd32;
  localparam logic [7:0] CHR_ZERO  = 8'd48;
  localparam logic [7:0] CHR_NINE  = 8'd57;

  // Calendar constants (400-year era, days from 0000-03-01 to 1970-01-01).
  localparam int unsigned DAYS_PER_ERA     = 146097;
  localparam int unsigned EPOCH_DAY_OFFSET = 719468;
  localparam int unsigned YEARS_PER_ERA    = 400;

  // Days from March 1 to the first of month index mm (0 = March).
  function automatic logic [8:0] month_start_day(input logic [3:0] mm);
    logic [8:0] d;
    unique case (mm)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/ate_front.sv =====
// Character front end: whitespace trim, digit checks and field accumulators.
// Depends on ate_pkg; emits one parsed token per last character.
module ate_front import ate_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  ate_in_t    req_i,
  output logic       tok_push_o,
  output ate_token_t tok_o
);

  logic        started_q, started_d;
  logic [4:0]  pos_q, pos_d;
  logic [13:0] year_q, year_d;
  logic [6:0]  month_q, month_d;
  logic [6:0]  day_q, day_d;
  logic [6:0]  hour_q, hour_d;
  logic [6:0]  minute_q, minute_d;
  logic [6:0]  second_q, second_d;
  logic [9:0]  milli_q, milli_d;
  logic        bad_q, bad_d;

  logic       is_ws;
  logic       is_digit;
  logic [3:0] digit;
  logic       need;

  always_comb begin
    is_ws    = (req_i.char_code >= CHR_TAB && req_i.char_code <= CHR_CR) ||
               req_i.char_code == CHR_SPACE;
    is_digit = req_i.char_code >= CHR_ZERO && req_i.char_code <= CHR_NINE;
    digit    = is_digit ? req_i.char_code[3:0] : 4'd0;
    need     = pos_q <= POS_DAY_END || pos_q == 5'd9 || pos_q == 5'd10 ||
               pos_q == 5'd12 || pos_q == 5'd13 || pos_q == 5'd15 ||
               pos_q == 5'd16 || (pos_q >= 5'd18 && pos_q <= 5'd20);

    started_d = started_q;
    pos_d     = pos_q;
    year_d    = year_q;
    month_d   = month_q;
    day_d     = day_q;
    hour_d    = hour_q;
    minute_d  = minute_q;
    second_d  = second_q;
    milli_d   = milli_q;
    bad_d     = bad_q;
    tok_push_o = 1'b0;

    if (accept_i && (started_q || !is_ws)) begin
      started_d = 1'b1;
      if (need) begin
        if (!is_digit) begin
          bad_d = 1'b1;
        end else begin
          priority if (pos_q <= POS_YEAR_END) begin
            year_d = 14'((18'(year_q) * 18'd10) + 18'(digit));
          end else if (pos_q <= POS_MONTH_END) begin
            month_d = 7'((11'(month_q) * 11'd10) + 11'(digit));
          end else if (pos_q <= POS_DAY_END) begin
            day_d = 7'((11'(day_q) * 11'd10) + 11'(digit));
          end else if (pos_q <= POS_HOUR_END) begin
            hour_d = 7'((11'(hour_q) * 11'd10) + 11'(digit));
          end else if (pos_q <= POS_MINUTE_END) begin
            minute_d = 7'((11'(minute_q) * 11'd10) + 11'(digit));
          end else if (pos_q <= POS_SECOND_END) begin
            second_d = 7'((11'(second_q) * 11'd10) + 11'(digit));
          end else begin
            milli_d = 10'((14'(milli_q) * 14'd10) + 14'(digit));
          end
        end
      end
      if (pos_q < TOKEN_LEN) begin
        pos_d = pos_q + 5'd1;
      end
    end

    // Token snapshot taken after this character is folded in.
    tok_o.year         = year_d;
    tok_o.month        = month_d;
    tok_o.day          = day_d;
    tok_o.hour         = hour_d;
    tok_o.minute       = minute_d;
    tok_o.second       = second_d;
    tok_o.milli        = milli_d;
    tok_o.format_error = bad_d || pos_d < TOKEN_LEN;

    if (accept_i && req_i.last_char) begin
      tok_push_o = 1'b1;
      started_d  = 1'b0;
      pos_d      = 5'd0;
      year_d     = 14'd0;
      month_d    = 7'd0;
      day_d      = 7'd0;
      hour_d     = 7'd0;
      minute_d   = 7'd0;
      second_d   = 7'd0;
      milli_d    = 10'd0;
      bad_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      pos_q     <= 5'd0;
      year_q    <= 14'd0;
      month_q   <= 7'd0;
      day_q     <= 7'd0;
      hour_q    <= 7'd0;
      minute_q  <= 7'd0;
      second_q  <= 7'd0;
      milli_q   <= 10'd0;
      bad_q     <= 1'b0;
    end else begin
      started_q <= started_d;
      pos_q     <= pos_d;
      year_q    <= year_d;
      month_q   <= month_d;
      day_q     <= day_d;
      hour_q    <= hour_d;
      minute_q  <= minute_d;
      second_q  <= second_d;
      milli_q   <= milli_d;
      bad_q     <= bad_d;
    end
  end

endmodule

// ===== rtl/ate_queue.sv =====
// Small token queue between the front end and the converter.
// Depends on ate_pkg for the token type; DEPTH must be 2 or more.
module ate_queue import ate_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  ate_token_t data_i,
  output logic       full_o,
  input  logic       pop_i,
  output ate_token_t data_o,
  output logic       empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  ate_token_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = count_q == CntW'(DEPTH);
  assign empty_o = count_q == '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/ate_back.sv =====
// Calendar converter: parsed token to signed microseconds since 1970 UTC.
// Depends on ate_pkg; multi-cycle sequencer plus one result register.
module ate_back import ate_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ate_token_t tok_i,
  input  logic       tok_empty_i,
  output logic       tok_pop_o,
  output ate_out_t   rsp_o,
  output logic       empty_o,
  input  logic       pop_i
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MON  = 4'd1;
  localparam logic [3:0] ST_ERA  = 4'd2;
  localparam logic [3:0] ST_YOE  = 4'd3;
  localparam logic [3:0] ST_DOE  = 4'd4;
  localparam logic [3:0] ST_DAYS = 4'd5;
  localparam logic [3:0] ST_SEC  = 4'd6;
  localparam logic [3:0] ST_SUM  = 4'd7;
  localparam logic [3:0] ST_US   = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  ate_out_t   rsp_q, rsp_d;

  // Datapath registers, one group per step.
  ate_token_t         tok_q, tok_d;
  logic [14:0]        yp_q, yp_d;        // March-based year plus 400
  logic [3:0]         mm_q, mm_d;        // month index from March
  logic [5:0]         eq_q, eq_d;        // era quotient estimate
  logic signed [6:0]  era_q, era_d;
  logic [8:0]         yoe_q, yoe_d;
  logic [17:0]        doe_q, doe_d;
  logic signed [24:0] eraday_q, eraday_d;
  logic signed [24:0] days_q, days_d;
  logic signed [41:0] dsec_q, dsec_d;
  logic [18:0]        hms_q, hms_d;
  logic signed [41:0] secs_q, secs_d;
  logic [41:0]        plo_q, plo_d;
  logic signed [40:0] phi_q, phi_d;

  logic [6:0]         m0;
  logic [12:0]        m_prod;
  logic [3:0]         m_quo;
  logic [6:0]         m_rem;
  logic [3:0]         m_idx;
  logic signed [16:0] y_adj;
  logic [29:0]        e_prod;
  logic [14:0]        e_rem;
  logic [5:0]         e_quo;
  logic [1:0]         cent;
  logic signed [20:0] sec_hi;
  logic [61:0]        us_full;
  logic               slot_free;

  assign rsp_o     = rsp_q;
  assign empty_o   = !out_valid_q;
  assign slot_free = !out_valid_q || pop_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    rsp_d       = rsp_q;
    tok_pop_o   = 1'b0;
    tok_d       = tok_q;
    yp_d        = yp_q;
    mm_d        = mm_q;
    eq_d        = eq_q;
    era_d       = era_q;
    yoe_d       = yoe_q;
    doe_d       = doe_q;
    eraday_d    = eraday_q;
    days_d      = days_q;
    dsec_d      = dsec_q;
    hms_d       = hms_q;
    secs_d      = secs_q;
    plo_d       = plo_q;
    phi_d       = phi_q;

    // Month normalization: month-1 split into years and a 0..11 index.
    m0     = tok_q.month - 7'd1;
    m_prod = 13'(m0) * 13'd43;          // 43/512 ~ 1/12, exact for 7 bits
    m_quo  = m_prod[12:9];
    m_rem  = m0 - 7'(m_quo) * 7'd12;
    if (m_rem >= 7'd12) begin
      m_quo = m_quo + 4'd1;
      m_rem = m_rem - 7'd12;
    end
    if (tok_q.month == 7'd0) begin
      y_adj = 17'($signed({3'b000, tok_q.year})) - 17'sd1;
      m_idx = 4'd11;
    end else begin
      y_adj = 17'($signed({3'b000, tok_q.year})) + 17'($signed({1'b0, m_quo}));
      m_idx = m_rem[3:0];
    end
    // January and February belong to the previous March-based year.
    if (m_idx <= 4'd1) begin
      y_adj = y_adj - 17'sd1;
    end

    // Era: floor((y+400)/400) via reciprocal 41944/2^24 with one correction.
    e_prod = 30'(yp_q) * 30'd41944;
    e_rem  = yp_q - 15'(eq_q * 15'd400);
    e_quo  = eq_q;
    if (e_rem >= 15'(YEARS_PER_ERA)) begin
      e_rem = e_rem - 15'(YEARS_PER_ERA);
      e_quo = eq_q + 6'd1;
    end

    cent   = 2'(yoe_q >= 9'd100) + 2'(yoe_q >= 9'd200) + 2'(yoe_q >= 9'd300);
    sec_hi = secs_q[41:21];
    us_full = (62'(phi_q) <<< 21) + 62'(plo_q);

    unique case (state_q)
      ST_IDLE: begin
        if (!tok_empty_i) begin
          tok_d     = tok_i;
          tok_pop_o = 1'b1;
          state_d   = ST_MON;
        end
      end
      ST_MON: begin
        yp_d    = 15'(y_adj + 17'sd400);
        mm_d    = (m_idx >= 4'd2) ? m_idx - 4'd2 : m_idx + 4'd10;
        state_d = ST_ERA;
      end
      ST_ERA: begin
        eq_d    = e_prod[29:24];
        state_d = ST_YOE;
      end
      ST_YOE: begin
        era_d   = 7'($signed({1'b0, e_quo})) - 7'sd1;
        yoe_d   = e_rem[8:0];
        state_d = ST_DOE;
      end
      ST_DOE: begin
        doe_d = 18'(yoe_q) * 18'd365 + 18'(yoe_q[8:2]) - 18'(cent) +
                18'(month_start_day(mm_q));
        eraday_d = 25'(era_q) * $signed(25'(DAYS_PER_ERA));
        state_d  = ST_DAYS;
      end
      ST_DAYS: begin
        days_d = eraday_q + $signed(25'(doe_q)) - $signed(25'(EPOCH_DAY_OFFSET)) +
                 $signed(25'(tok_q.day)) - 25'sd1;
        state_d = ST_SEC;
      end
      ST_SEC: begin
        dsec_d = 42'(days_q) * 42'sd86400;
        hms_d  = 19'(tok_q.hour) * 19'd3600 + 19'(tok_q.minute) * 19'd60 +
                 19'(tok_q.second);
        state_d = ST_SUM;
      end
      ST_SUM: begin
        secs_d  = dsec_q + $signed(42'(hms_q));
        state_d = ST_US;
      end
      ST_US: begin
        // Seconds split at bit 21 keeps each product near 21 x 20 bits.
        plo_d   = 42'(secs_q[20:0]) * 42'd1000000 + 42'(tok_q.milli) * 42'd1000;
        phi_d   = 41'(sec_hi) * 41'sd1000000;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (slot_free) begin
          rsp_d.format_error = tok_q.format_error;
          rsp_d.epoch_us     = tok_q.format_error ? 60'sd0 : $signed(us_full[59:0]);
          out_valid_d        = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (pop_i && out_valid_q && !(state_q == ST_OUT)) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q    <= rsp_d;
    tok_q    <= tok_d;
    yp_q     <= yp_d;
    mm_q     <= mm_d;
    eq_q     <= eq_d;
    era_q    <= era_d;
    yoe_q    <= yoe_d;
    doe_q    <= doe_d;
    eraday_q <= eraday_d;
    days_q   <= days_d;
    dsec_q   <= dsec_d;
    hms_q    <= hms_d;
    secs_q   <= secs_d;
    plo_q    <= plo_d;
    phi_q    <= phi_d;
  end

endmodule

// ===== rtl/ascii_timestamp_to_epoch_us_core.sv =====
// ASCII timestamp (YYYYMMDD?HH?MM?SS?mmm) to signed epoch microseconds, UTC.
// Throughput: one character per cycle while full is low; the converter finishes one token before it takes the next.
// A result reaches the output after its token passes the queue and the converter states MON through OUT.
// Short tokens arriving faster than the converter finishes them fill the token queue.
// Reset (rst_ni low, async): parser state cleared, queue and result emptied.
module ascii_timestamp_to_epoch_us_core import ate_pkg::*; #(
  parameter int unsigned TOKEN_QUEUE_DEPTH = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  // character side
  input  logic     push,
  output logic     full,
  input  ate_in_t  in_req_i,
  // result side
  output logic     empty,
  input  logic     pop,
  output ate_out_t out_rsp_o
);

  // The front end folds every accepted character into running field
  // accumulators in the same cycle, so it never stalls on its own. On the
  // last character of a token it pushes the parsed fields, with the error
  // flag already decided, into the token queue.
  //
  // full follows the token queue only: a non-last character would not need
  // a slot, but keeping one rule keeps the front end free of lookahead.

  logic       accept;
  logic       tok_push;
  ate_token_t tok_in;
  ate_token_t tok_out;
  logic       tok_full;
  logic       tok_empty;
  logic       tok_pop;

  assign accept = push && !full;
  assign full   = tok_full;

  ate_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_i      (in_req_i),
    .tok_push_o (tok_push),
    .tok_o      (tok_in)
  );

  ate_queue #(
    .DEPTH (TOKEN_QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tok_push),
    .data_i  (tok_in),
    .full_o  (tok_full),
    .pop_i   (tok_pop),
    .data_o  (tok_out),
    .empty_o (tok_empty)
  );

  // The converter walks one token through month normalization, era split,
  // day count, seconds and the split microsecond multiply, one step per
  // cycle, then parks the result in its output register once the previous
  // one is popped. It starts the next token while a result waits to be popped.
  ate_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (tok_out),
    .tok_empty_i (tok_empty),
    .tok_pop_o   (tok_pop),
    .rsp_o       (out_rsp_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule
